// File: hw/rtl/ry422_pkg.sv
package ry422_pkg;

    // Component and bus widths.
    localparam int unsigned COMP_W      = 8;
    localparam int unsigned IN_DATA_W   = 3 * COMP_W;
    localparam int unsigned OUT_DATA_W  = 4 * COMP_W;
    localparam int unsigned SUM_W       = 18;

    // BT.601 full-range coefficients in 8.8 fixed point.
    localparam logic signed [SUM_W-1:0] COEF_YR = 18'sd77;
    localparam logic signed [SUM_W-1:0] COEF_YG = 18'sd150;
    localparam logic signed [SUM_W-1:0] COEF_YB = 18'sd29;
    localparam logic signed [SUM_W-1:0] COEF_UR = 18'sd43;
    localparam logic signed [SUM_W-1:0] COEF_UG = 18'sd85;
    localparam logic signed [SUM_W-1:0] COEF_C  = 18'sd128;
    localparam logic signed [SUM_W-1:0] COEF_VG = 18'sd107;
    localparam logic signed [SUM_W-1:0] COEF_VB = 18'sd21;
    localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = 18'sd128;
    localparam logic signed [SUM_W-1:0] MAX_VAL       = 18'sd255;

    // One registered input pixel together with its column parity.
    typedef struct packed {
        logic              odd;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } pix_t;

    // One converted result.
    typedef struct packed {
        logic              odd;
        logic [COMP_W-1:0] packed_chroma;
        logic [COMP_W-1:0] red_chroma;
        logic [COMP_W-1:0] blue_chroma;
        logic [COMP_W-1:0] luma;
    } res_t;

    // Saturate a signed value to the unsigned 8-bit range.
    function automatic logic [COMP_W-1:0] clamp8(input logic signed [SUM_W-1:0] val);
        logic [COMP_W-1:0] res;
        if (val < 0)
        begin
            res = '0;
        end
        else if (val > MAX_VAL)
        begin
            res = '1;
        end
        else
        begin
            res = val[COMP_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/ry422_in_stage.sv
module ry422_in_stage
    import ry422_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 down_ready,
    output logic                 pix_valid,
    output pix_t                 pix
);

    logic pix_valid_reg;
    logic parity_reg;
    logic parity_next;
    logic odd_now;
    pix_t pix_reg;

    // The stage takes a new transaction whenever its register is empty or drains.
    assign s_axis_tready = !pix_valid_reg || down_ready;

    // Start of frame forces an even column for this pixel; the parity then toggles.
    assign odd_now     = s_axis_tuser ? 1'b0 : parity_reg;
    assign parity_next = !odd_now;

    // Control state: valid flag and column parity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            parity_reg    <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            pix_valid_reg <= s_axis_tvalid;
            if (s_axis_tvalid)
            begin
                parity_reg <= parity_next;
            end
        end
    end

    // Pixel payload register.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            pix_reg.odd   <= odd_now;
            pix_reg.blue  <= s_axis_tdata[COMP_W-1:0];
            pix_reg.green <= s_axis_tdata[2*COMP_W-1:COMP_W];
            pix_reg.red   <= s_axis_tdata[3*COMP_W-1:2*COMP_W];
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule

// File: hw/rtl/ry422_csc.sv
module ry422_csc
    import ry422_pkg::*;
(
    input  pix_t pix,
    output res_t res
);

    logic signed [SUM_W-1:0] r_s;
    logic signed [SUM_W-1:0] g_s;
    logic signed [SUM_W-1:0] b_s;
    logic signed [SUM_W-1:0] y_sum;
    logic signed [SUM_W-1:0] u_sum;
    logic signed [SUM_W-1:0] v_sum;
    logic signed [SUM_W-1:0] y_val;
    logic signed [SUM_W-1:0] u_val;
    logic signed [SUM_W-1:0] v_val;
    logic [COMP_W-1:0]       y_c;
    logic [COMP_W-1:0]       u_c;
    logic [COMP_W-1:0]       v_c;

    // Zero-extend the components into the signed sum width.
    assign r_s = $signed({{(SUM_W-COMP_W){1'b0}}, pix.red});
    assign g_s = $signed({{(SUM_W-COMP_W){1'b0}}, pix.green});
    assign b_s = $signed({{(SUM_W-COMP_W){1'b0}}, pix.blue});

    // Constant-coefficient products; all sums stay within 18 signed bits.
    assign y_sum = COEF_YR * r_s + COEF_YG * g_s + COEF_YB * b_s;
    assign u_sum = COEF_C * b_s - COEF_UR * r_s - COEF_UG * g_s;
    assign v_sum = COEF_C * r_s - COEF_VG * g_s - COEF_VB * b_s;

    // Arithmetic shift floors toward minus infinity; chroma gets its offset.
    assign y_val = y_sum >>> 8;
    assign u_val = (u_sum >>> 8) + CHROMA_OFFSET;
    assign v_val = (v_sum >>> 8) + CHROMA_OFFSET;

    assign y_c = clamp8(y_val);
    assign u_c = clamp8(u_val);
    assign v_c = clamp8(v_val);

    // Interleaved chroma: U on even columns, V on odd columns.
    assign res.luma          = y_c;
    assign res.blue_chroma   = u_c;
    assign res.red_chroma    = v_c;
    assign res.odd           = pix.odd;
    assign res.packed_chroma = pix.odd ? v_c : u_c;

endmodule

// File: hw/rtl/ry422_out_stage.sv
module ry422_out_stage
    import ry422_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    input  res_t                  res,
    output logic                  up_ready,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser
);

    logic m_valid_reg;
    res_t res_reg;

    // The result register loads when empty or when its transaction completes.
    assign up_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (up_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {res_reg.packed_chroma, res_reg.red_chroma,
                            res_reg.blue_chroma, res_reg.luma};
    assign m_axis_tuser  = res_reg.odd;

endmodule

// File: hw/rtl/rgb_to_yuv422_pixel_converter.sv
// RGB to YCbCr (BT.601 full range) converter for 4:2:2 video. Each input
// transaction carries one pixel (blue, green, red bytes) and yields one result
// transaction with clamped Y, U and V, the column parity and the interleaved
// chroma byte (U on even columns, V on odd). Throughput is one pixel per clock
// while the output is not stalled; an input register, the constant-coefficient
// matrix and a result register make up the path. Column parity toggles per pixel
// and is cleared by the start-of-frame flag, so frames must have an even width.
module rgb_to_yuv422_pixel_converter
    import ry422_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] blue, [15:8] green, [23:16] red
    input  logic                  s_axis_tuser,   // [0] start_of_frame
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] luma, [15:8] blue_chroma,
                                                  // [23:16] red_chroma, [31:24] packed_chroma
    output logic                  m_axis_tuser    // [0] odd_column
);

    logic pix_valid;
    logic down_ready;
    pix_t pix;
    res_t res;

    // Input register and column parity.
    ry422_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .down_ready    (down_ready),
        .pix_valid     (pix_valid),
        .pix           (pix)
    );

    // Color space matrix with clamping.
    ry422_csc u_csc (
        .pix (pix),
        .res (res)
    );

    // Result register toward the output stream.
    ry422_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (pix_valid),
        .res           (res),
        .up_ready      (down_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: dv/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ry422_pkg::*;

    // Coefficients of the BT.601 full-range matrix in 8.8 fixed point.
    localparam int K_YR = 77;
    localparam int K_YG = 150;
    localparam int K_YB = 29;
    localparam int K_UR = 43;
    localparam int K_UG = 85;
    localparam int K_C  = 128;
    localparam int K_VG = 107;
    localparam int K_VB = 21;
    localparam int CHROMA_BIAS = 128;
    localparam int BYTE_MAX = 255;

    localparam int STALL_LIMIT   = 2000;
    localparam int CALM_ITEMS    = 100;
    localparam int RANDOM_ITEMS  = 750;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic       sof;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_item_t;

    typedef struct {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       odd;
        logic [7:0] interleaved;
    } yuv_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    pixel_item_t pixel_queue[$];
    yuv_result_t yuv_expected[$];

    pixel_item_t next_pixel;
    pixel_item_t taken_pixel;
    yuv_result_t predicted;
    yuv_result_t observed;
    logic        next_valid;
    logic        in_taken;
    logic        column_odd;
    logic        calm;
    int          gap_left;
    int          stall_left;
    int          mismatches;
    int          idle_cycles;

    rgb_to_yuv422_pixel_converter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    // Saturate a signed sum to one unsigned byte.
    function automatic logic [7:0] saturate_byte(input int val);
        logic [7:0] res;
        if (val < 0)
        begin
            res = 8'd0;
        end
        else if (val > BYTE_MAX)
        begin
            res = 8'(BYTE_MAX);
        end
        else
        begin
            res = 8'(val);
        end
        return res;
    endfunction

    // Convert one pixel at the given column parity. The shifts are arithmetic,
    // so negative chroma sums round toward minus infinity.
    function automatic yuv_result_t convert_pixel(input pixel_item_t px, input logic odd);
        int          r;
        int          g;
        int          b;
        yuv_result_t res;
        r = int'(px.red);
        g = int'(px.green);
        b = int'(px.blue);
        res.luma = saturate_byte((K_YR * r + K_YG * g + K_YB * b) >>> 8);
        res.cb   = saturate_byte(((K_C * b - K_UR * r - K_UG * g) >>> 8) + CHROMA_BIAS);
        res.cr   = saturate_byte(((K_C * r - K_VG * g - K_VB * b) >>> 8) + CHROMA_BIAS);
        res.odd  = odd;
        res.interleaved = odd ? res.cr : res.cb;
        return res;
    endfunction

    task automatic add_pixel(input logic sof, input logic [7:0] b, input logic [7:0] g,
                             input logic [7:0] r);
        pixel_item_t px;
        px.sof   = sof;
        px.blue  = b;
        px.green = g;
        px.red   = r;
        pixel_queue.push_back(px);
    endtask

    // Random component value biased toward the ends of the range.
    function automatic logic [7:0] pick_component();
        logic [7:0] val;
        case ($urandom_range(0, 7))
            0: val = 8'd0;
            1: val = 8'd255;
            default: val = 8'($urandom);
        endcase
        return val;
    endfunction

    // Input driver: presents pending pixels, with random gaps between them.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                end
                else if (pixel_queue.size() > 0)
                begin
                    next_pixel = pixel_queue.pop_front();
                    next_valid = 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                    begin
                        gap_left = $urandom_range(1, 16);
                    end
                end
                s_axis_tvalid <= next_valid;
                if (next_valid)
                begin
                    s_axis_tdata <= {next_pixel.red, next_pixel.green, next_pixel.blue};
                    s_axis_tuser <= next_pixel.sof;
                end
                else
                begin
                    s_axis_tdata <= IN_DATA_W'($urandom);
                    s_axis_tuser <= 1'($urandom);
                end
            end
        end
    end

    // Output back-pressure in random bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(1, 16);
                end
            end
        end
    end

    // Monitor: predicts on each input transaction, checks each output transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken_pixel.blue  = s_axis_tdata[7:0];
                taken_pixel.green = s_axis_tdata[15:8];
                taken_pixel.red   = s_axis_tdata[23:16];
                taken_pixel.sof   = s_axis_tuser;
                if (taken_pixel.sof)
                begin
                    column_odd = 1'b0;
                end
                yuv_expected.push_back(convert_pixel(taken_pixel, column_odd));
                column_odd = ~column_odd;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                observed.luma        = m_axis_tdata[7:0];
                observed.cb          = m_axis_tdata[15:8];
                observed.cr          = m_axis_tdata[23:16];
                observed.interleaved = m_axis_tdata[31:24];
                observed.odd         = m_axis_tuser;
                if (yuv_expected.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected result: Y=%0d U=%0d V=%0d odd=%0b packed=%0d",
                                 $realtime, observed.luma, observed.cb, observed.cr,
                                 observed.odd, observed.interleaved);
                    end
                end
                else
                begin
                    predicted = yuv_expected.pop_front();
                    if (observed.luma !== predicted.luma || observed.cb !== predicted.cb
                        || observed.cr !== predicted.cr || observed.odd !== predicted.odd
                        || observed.interleaved !== predicted.interleaved)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: expected Y=%0d U=%0d V=%0d odd=%0b packed=%0d",
                                     $realtime, predicted.luma, predicted.cb, predicted.cr,
                                     predicted.odd, predicted.interleaved);
                            $display("%0t: actual   Y=%0d U=%0d V=%0d odd=%0b packed=%0d",
                                     $realtime, observed.luma, observed.cb, observed.cr,
                                     observed.odd, observed.interleaved);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side ends the run.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // The last stretch of the run goes without gaps or stalls.
    always @(posedge clk)
    begin
        calm <= (pixel_queue.size() < CALM_ITEMS);
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int n_rows;
        int n_cols;
        int n_noise;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        in_taken      = 1'b0;
        column_odd    = 1'b0;
        calm          = 1'b0;
        gap_left      = 0;
        stall_left    = 0;
        mismatches    = 0;
        idle_cycles   = 0;

        // Directed part: pixels without a start mark right after reset, extremes,
        // primaries and secondaries, and start marks on both parities.
        add_pixel(1'b0, 8'd0,   8'd0,   8'd0);
        add_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        add_pixel(1'b0, 8'd255, 8'd0,   8'd0);
        add_pixel(1'b1, 8'd0,   8'd255, 8'd0);
        add_pixel(1'b0, 8'd0,   8'd0,   8'd255);
        add_pixel(1'b0, 8'd0,   8'd255, 8'd255);
        add_pixel(1'b1, 8'd255, 8'd0,   8'd255);
        add_pixel(1'b1, 8'd255, 8'd255, 8'd0);
        add_pixel(1'b0, 8'd1,   8'd1,   8'd1);
        add_pixel(1'b0, 8'd128, 8'd128, 8'd128);
        add_pixel(1'b0, 8'd127, 8'd127, 8'd127);
        add_pixel(1'b1, 8'd170, 8'd85,  8'd170);
        add_pixel(1'b0, 8'd85,  8'd170, 8'd85);
        add_pixel(1'b0, 8'd0,   8'd255, 8'd255);
        add_pixel(1'b0, 8'd255, 8'd0,   8'd0);
        add_pixel(1'b0, 8'd0,   8'd0,   8'd255);
        add_pixel(1'b0, 8'd255, 8'd255, 8'd0);
        add_pixel(1'b1, 8'd16,  8'd235, 8'd240);
        add_pixel(1'b1, 8'd240, 8'd16,  8'd1);

        // Random part: mostly whole frames of even width, some loose pixels with
        // start marks anywhere.
        while (pixel_queue.size() < RANDOM_ITEMS + 19)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                n_noise = $urandom_range(1, 6);
                repeat (n_noise)
                begin
                    add_pixel(($urandom_range(0, 3) == 0), pick_component(),
                              pick_component(), pick_component());
                end
            end
            else
            begin
                n_cols = 2 * $urandom_range(1, 4);
                n_rows = $urandom_range(1, 4);
                for (int i = 0; i < n_cols * n_rows; i++)
                begin
                    add_pixel((i == 0), pick_component(), pick_component(),
                              pick_component());
                end
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pixel_queue.size() == 0 && !s_axis_tvalid && yuv_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && yuv_expected.size() == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
